@@ design/gbc_pkg.sv @@
// shared widths, constants and types of the goertzel bin contrast block
package gbc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEFF_W  = 19;
    localparam int ST_W     = 48;
    localparam int POW_W    = 63;
    localparam int EN_W     = 43;
    localparam int Q_W      = 32;
    localparam int LEN_W    = 13;
    localparam int ACC_W    = 104;
    localparam int CH_W     = 24;
    localparam int OPA_W    = 72;
    localparam int OPB_W    = 48;
    localparam int DIV_W    = 96;
    localparam int DEN_W    = 64;
    localparam int R_W      = 52;
    localparam int S_W      = 54;
    localparam int NUM_BINS = 3;
    localparam int TDATA_W  = 248;

    localparam logic [LEN_W-1:0] MAX_WINDOW_SAMPLES = LEN_W'(4096);
    localparam logic [POW_W-1:0] POW_MAX    = '1;
    localparam logic [EN_W-1:0]  ENERGY_MAX = '1;
    localparam logic [OPB_W-1:0] SCORE_SCALE = OPB_W'(256000);

    localparam logic [1:0] REG_COEFF_TARGET = 2'd0;
    localparam logic [1:0] REG_COEFF_LOWER  = 2'd1;
    localparam logic [1:0] REG_COEFF_UPPER  = 2'd2;

    typedef logic signed [COEFF_W-1:0] coeff_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       close;
        logic [LEN_W-1:0]           len;
    } item_t;

    typedef struct packed {
        logic [OPA_W-1:0] a;
        logic [OPB_W-1:0] b;
        logic [1:0]       na_m1;
        logic             nb_m1;
        logic             neg;
        logic             clr;
    } mac_cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0] window_length;
        logic [Q_W-1:0]   contrast;
        logic [Q_W-1:0]   score;
        logic [EN_W-1:0]  total_energy;
        logic [POW_W-1:0] neighbor_power;
        logic [POW_W-1:0] target_power;
    } result_t;

endpackage

@@ design/gbc_front.sv @@
// front end: accepts samples, counts the window, tags closing samples, two-entry queue
module gbc_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [gbc_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                  s_last,
    output logic                  q_valid,
    output gbc_pkg::item_t        q_item,
    input  logic                  q_pop
);

    logic [gbc_pkg::LEN_W-1:0] cnt_reg, cnt_next, cnt_inc;
    gbc_pkg::item_t            slot_reg [2];
    logic                      wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                fill_reg, fill_next;
    logic                      push, pop, close;

    assign s_ready = (fill_reg != 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid & s_ready;
    assign pop     = q_pop & q_valid;

    assign cnt_inc  = cnt_reg + 1'b1;
    assign close    = s_last | (cnt_inc == gbc_pkg::MAX_WINDOW_SAMPLES);
    assign cnt_next = close ? '0 : cnt_inc;

    always_comb begin
        fill_next = fill_reg;
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                cnt_reg    <= cnt_next;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg].sample <= s_sample;
            slot_reg[wr_ptr_reg].close  <= close;
            slot_reg[wr_ptr_reg].len    <= cnt_inc;
        end
    end

endmodule

@@ design/gbc_mac.sv @@
// shared 24x24 multiply-accumulate unit, one partial product per cycle
module gbc_mac (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     go,
    input  gbc_pkg::mac_cmd_t        cmd,
    output logic                     done,
    output logic signed [gbc_pkg::ACC_W-1:0] acc
);

    logic signed [gbc_pkg::ACC_W-1:0] acc_reg, acc_next, ext;
    logic [gbc_pkg::OPA_W-1:0] a_reg;
    logic [gbc_pkg::OPB_W-1:0] b_reg;
    logic [1:0]  ia_reg, na_m1_reg;
    logic        ib_reg, nb_m1_reg, neg_reg, busy_reg, done_reg;
    logic [gbc_pkg::CH_W-1:0]   a_ch, b_ch;
    logic [2*gbc_pkg::CH_W-1:0] prod;
    logic [1:0]  sh;

    assign done = done_reg;
    assign acc  = acc_reg;

    always_comb begin
        case (ia_reg)
            2'd0:    a_ch = a_reg[gbc_pkg::CH_W-1:0];
            2'd1:    a_ch = a_reg[2*gbc_pkg::CH_W-1:gbc_pkg::CH_W];
            default: a_ch = a_reg[3*gbc_pkg::CH_W-1:2*gbc_pkg::CH_W];
        endcase
        b_ch = ib_reg ? b_reg[2*gbc_pkg::CH_W-1:gbc_pkg::CH_W] : b_reg[gbc_pkg::CH_W-1:0];
        prod = a_ch * b_ch;
        sh   = ia_reg + 2'(ib_reg);
        case (sh)
            2'd0:    ext = gbc_pkg::ACC_W'(prod);
            2'd1:    ext = gbc_pkg::ACC_W'(prod) << gbc_pkg::CH_W;
            2'd2:    ext = gbc_pkg::ACC_W'(prod) << (2 * gbc_pkg::CH_W);
            default: ext = gbc_pkg::ACC_W'(prod) << (3 * gbc_pkg::CH_W);
        endcase
        acc_next = neg_reg ? acc_reg - ext : acc_reg + ext;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (go) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && ib_reg == nb_m1_reg && ia_reg == na_m1_reg) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            a_reg     <= cmd.a;
            b_reg     <= cmd.b;
            na_m1_reg <= cmd.na_m1;
            nb_m1_reg <= cmd.nb_m1;
            neg_reg   <= cmd.neg;
            ia_reg    <= '0;
            ib_reg    <= 1'b0;
            if (cmd.clr) begin
                acc_reg <= '0;
            end
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            if (ib_reg == nb_m1_reg) begin
                ib_reg <= 1'b0;
                ia_reg <= ia_reg + 1'b1;
            end else begin
                ib_reg <= 1'b1;
            end
        end
    end

endmodule

@@ design/gbc_div.sv @@
// restoring divider, one quotient bit per cycle, saturates at 32 bits
module gbc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        go,
    input  logic [gbc_pkg::DIV_W-1:0]   num,
    input  logic [gbc_pkg::DEN_W-1:0]   den,
    output logic                        done,
    output logic [gbc_pkg::Q_W-1:0]     quo
);

    logic [gbc_pkg::DIV_W-1:0] rem_reg, dsh_reg;
    logic [gbc_pkg::Q_W-1:0]   q_reg;
    logic [4:0]                bit_reg;
    logic                      busy_reg, done_reg, ge;

    assign done = done_reg;
    assign quo  = q_reg;
    assign ge   = (rem_reg >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (go) begin
                if (num >= {den, {gbc_pkg::Q_W{1'b0}}}) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg && bit_reg == 5'd0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            rem_reg <= num;
            dsh_reg <= {1'b0, den, {(gbc_pkg::Q_W-1){1'b0}}};
            bit_reg <= 5'd31;
            q_reg   <= (num >= {den, {gbc_pkg::Q_W{1'b0}}}) ? '1 : '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[gbc_pkg::Q_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
            bit_reg <= bit_reg - 1'b1;
        end
    end

endmodule

@@ design/gbc_back.sv @@
// back end: resonator sequencer, bin powers, score and contrast, result register
module gbc_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gbc_pkg::coeff_t       coeff [gbc_pkg::NUM_BINS],
    input  logic                  q_valid,
    input  gbc_pkg::item_t        q_item,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output gbc_pkg::result_t      m_result
);

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_R_MAC = 13'b0000000000010,
        ST_R_UPD = 13'b0000000000100,
        ST_P_RMAC = 13'b0000000001000,
        ST_P_S2  = 13'b0000000010000,
        ST_P_S1  = 13'b0000000100000,
        ST_P_X   = 13'b0000001000000,
        ST_P_SAVE = 13'b0000010000000,
        ST_NB    = 13'b0000100000000,
        ST_D_MAC = 13'b0001000000000,
        ST_D_SC  = 13'b0010000000000,
        ST_D_CT  = 13'b0100000000000,
        ST_EMIT  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   fresh_reg;
    logic [1:0] k_reg;

    logic signed [gbc_pkg::ST_W-1:0] prev_reg  [gbc_pkg::NUM_BINS];
    logic signed [gbc_pkg::ST_W-1:0] prev2_reg [gbc_pkg::NUM_BINS];
    logic [gbc_pkg::EN_W-1:0]  energy_reg;
    logic [gbc_pkg::POW_W-1:0] pw_reg [gbc_pkg::NUM_BINS];
    logic [gbc_pkg::POW_W-1:0] nb_reg;
    logic signed [gbc_pkg::R_W-1:0] r_reg;
    logic [gbc_pkg::Q_W-1:0]   score_reg;
    logic signed [gbc_pkg::SAMPLE_W-1:0] x_reg;
    logic                      close_reg;
    logic [gbc_pkg::LEN_W-1:0] len_reg;
    logic                      out_valid_reg;
    gbc_pkg::result_t          out_reg;

    gbc_pkg::mac_cmd_t cmd;
    logic              mac_go, mac_done, div_go, div_done;
    logic signed [gbc_pkg::ACC_W-1:0] acc;
    logic [gbc_pkg::DIV_W-1:0] div_num;
    logic [gbc_pkg::DEN_W-1:0] div_den;
    logic [gbc_pkg::Q_W-1:0]   quo;

    logic signed [gbc_pkg::COEFF_W-1:0] c_cur;
    logic signed [gbc_pkg::ST_W-1:0]    p_cur, p2_cur;
    logic [gbc_pkg::COEFF_W-1:0] c_mag;
    logic [gbc_pkg::ST_W-1:0]    p_mag, p2_mag;
    logic [gbc_pkg::R_W-1:0]     r_mag;
    logic signed [gbc_pkg::ACC_W-1:0] rnd;
    logic signed [gbc_pkg::R_W-1:0]   r_new;
    logic signed [gbc_pkg::S_W-1:0]   s_wide;
    logic signed [gbc_pkg::ST_W-1:0]  s_sat;
    logic [gbc_pkg::POW_W-1:0]  pw_clamp;
    logic signed [2*gbc_pkg::SAMPLE_W-1:0] sq_s;
    logic [gbc_pkg::EN_W:0]     esum;
    logic [gbc_pkg::POW_W:0]    nb_sum;
    logic                       out_free, take;

    assign c_cur  = coeff[k_reg];
    assign p_cur  = prev_reg[k_reg];
    assign p2_cur = prev2_reg[k_reg];
    assign c_mag  = c_cur[gbc_pkg::COEFF_W-1] ? ~c_cur + 1'b1 : c_cur;
    assign p_mag  = p_cur[gbc_pkg::ST_W-1] ? ~p_cur + 1'b1 : p_cur;
    assign p2_mag = p2_cur[gbc_pkg::ST_W-1] ? ~p2_cur + 1'b1 : p2_cur;
    assign r_mag  = r_reg[gbc_pkg::R_W-1] ? ~r_reg + 1'b1 : r_reg;

    // round half up, then drop the 16 fraction bits
    assign rnd    = acc + gbc_pkg::ACC_W'(32768);
    assign r_new  = rnd[gbc_pkg::R_W+15:16];
    assign s_wide = gbc_pkg::S_W'(x_reg) + gbc_pkg::S_W'(r_new) - gbc_pkg::S_W'(p2_cur);

    always_comb begin
        if (&s_wide[gbc_pkg::S_W-1:gbc_pkg::ST_W-1] || ~|s_wide[gbc_pkg::S_W-1:gbc_pkg::ST_W-1])
            s_sat = s_wide[gbc_pkg::ST_W-1:0];
        else if (s_wide[gbc_pkg::S_W-1])
            s_sat = {1'b1, {(gbc_pkg::ST_W-1){1'b0}}};
        else
            s_sat = {1'b0, {(gbc_pkg::ST_W-1){1'b1}}};
    end

    always_comb begin
        if (acc[gbc_pkg::ACC_W-1])
            pw_clamp = '0;
        else if (|acc[gbc_pkg::ACC_W-2:gbc_pkg::POW_W])
            pw_clamp = gbc_pkg::POW_MAX;
        else
            pw_clamp = acc[gbc_pkg::POW_W-1:0];
    end

    assign sq_s   = q_item.sample * q_item.sample;
    assign esum   = {1'b0, energy_reg} + (gbc_pkg::EN_W+1)'(unsigned'(sq_s));
    assign nb_sum = {1'b0, pw_reg[1]} + {1'b0, pw_reg[2]};

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_R_MAC, ST_P_RMAC: begin
                cmd.a     = gbc_pkg::OPA_W'(c_mag);
                cmd.b     = p_mag;
                cmd.nb_m1 = 1'b1;
                cmd.neg   = c_cur[gbc_pkg::COEFF_W-1] ^ p_cur[gbc_pkg::ST_W-1];
                cmd.clr   = 1'b1;
            end
            ST_P_S2: begin
                cmd.a     = gbc_pkg::OPA_W'(p2_mag);
                cmd.b     = p2_mag;
                cmd.na_m1 = 2'd1;
                cmd.nb_m1 = 1'b1;
                cmd.clr   = 1'b1;
            end
            ST_P_S1: begin
                cmd.a     = gbc_pkg::OPA_W'(p_mag);
                cmd.b     = p_mag;
                cmd.na_m1 = 2'd1;
                cmd.nb_m1 = 1'b1;
            end
            ST_P_X: begin
                // subtract R * prev2
                cmd.a     = gbc_pkg::OPA_W'(r_mag);
                cmd.b     = p2_mag;
                cmd.na_m1 = 2'd2;
                cmd.nb_m1 = 1'b1;
                cmd.neg   = ~(r_reg[gbc_pkg::R_W-1] ^ p2_cur[gbc_pkg::ST_W-1]);
            end
            ST_D_MAC: begin
                cmd.a     = gbc_pkg::OPA_W'(pw_reg[0]);
                cmd.b     = gbc_pkg::SCORE_SCALE;
                cmd.na_m1 = 2'd2;
                cmd.clr   = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

    assign mac_go = fresh_reg && (state_reg == ST_R_MAC || state_reg == ST_P_RMAC ||
                    state_reg == ST_P_S2 || state_reg == ST_P_S1 || state_reg == ST_P_X ||
                    state_reg == ST_D_MAC);
    assign div_go = fresh_reg && (state_reg == ST_D_SC || state_reg == ST_D_CT);

    always_comb begin
        if (state_reg == ST_D_SC) begin
            div_num = acc[gbc_pkg::DIV_W-1:0];
            div_den = gbc_pkg::DEN_W'({1'b0, energy_reg} + 1'b1);
        end else begin
            div_num = {{(gbc_pkg::DIV_W-gbc_pkg::POW_W-8){1'b0}}, pw_reg[0], 8'd0};
            div_den = {1'b0, nb_reg} + 1'b1;
        end
    end

    assign out_free = ~out_valid_reg | m_ready;
    assign take     = (state_reg == ST_IDLE) & q_valid;
    assign q_pop    = take;
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (q_valid) state_next = ST_R_MAC;
            ST_R_MAC:  if (mac_done) state_next = ST_R_UPD;
            ST_R_UPD: begin
                if (k_reg != 2'd2) state_next = ST_R_MAC;
                else if (close_reg) state_next = ST_P_RMAC;
                else state_next = ST_IDLE;
            end
            ST_P_RMAC: if (mac_done) state_next = ST_P_S2;
            ST_P_S2:   if (mac_done) state_next = ST_P_S1;
            ST_P_S1:   if (mac_done) state_next = ST_P_X;
            ST_P_X:    if (mac_done) state_next = ST_P_SAVE;
            ST_P_SAVE: state_next = (k_reg == 2'd2) ? ST_NB : ST_P_RMAC;
            ST_NB:     state_next = ST_D_MAC;
            ST_D_MAC:  if (mac_done) state_next = ST_D_SC;
            ST_D_SC:   if (div_done) state_next = ST_D_CT;
            ST_D_CT:   if (div_done) state_next = ST_EMIT;
            ST_EMIT:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fresh_reg     <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            energy_reg    <= '0;
            for (int i = 0; i < gbc_pkg::NUM_BINS; i++) begin
                prev_reg[i]  <= '0;
                prev2_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            fresh_reg <= (state_next != state_reg);
            if (state_reg == ST_EMIT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        k_reg      <= '0;
                        energy_reg <= esum[gbc_pkg::EN_W] ? gbc_pkg::ENERGY_MAX
                                                          : esum[gbc_pkg::EN_W-1:0];
                    end
                end
                ST_R_UPD: begin
                    prev2_reg[k_reg] <= p_cur;
                    prev_reg[k_reg]  <= s_sat;
                    k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 1'b1;
                end
                ST_P_SAVE: begin
                    k_reg <= (k_reg == 2'd2) ? 2'd0 : k_reg + 1'b1;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        energy_reg    <= '0;
                        for (int i = 0; i < gbc_pkg::NUM_BINS; i++) begin
                            prev_reg[i]  <= '0;
                            prev2_reg[i] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            x_reg     <= q_item.sample;
            close_reg <= q_item.close;
            len_reg   <= q_item.len;
        end
        if (state_reg == ST_P_RMAC && mac_done) begin
            r_reg <= r_new;
        end
        if (state_reg == ST_P_SAVE) begin
            pw_reg[k_reg] <= pw_clamp;
        end
        if (state_reg == ST_NB) begin
            nb_reg <= nb_sum[gbc_pkg::POW_W:1];
        end
        if (state_reg == ST_D_SC && div_done) begin
            score_reg <= quo;
        end
        if (state_reg == ST_EMIT && out_free) begin
            out_reg.target_power   <= pw_reg[0];
            out_reg.neighbor_power <= nb_reg;
            out_reg.total_energy   <= energy_reg;
            out_reg.score          <= score_reg;
            out_reg.contrast       <= quo;
            out_reg.window_length  <= len_reg;
        end
    end

    gbc_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (mac_go),
        .cmd     (cmd),
        .done    (mac_done),
        .acc     (acc)
    );

    gbc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (div_go),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (quo)
    );

endmodule

@@ design/goertzel_bin_contrast.sv @@
// top level: configuration registers, front end, back end and stream ports
// Tone probe over a window of signed 16-bit samples: three Goertzel resonators (target,
// lower and upper neighbor bin, coefficients 2cos(omega) in Q2.16 at APB offsets 0, 4, 8)
// plus a sum of squares; the sample with tlast set, or the 4096th, closes the window and
// yields one result. In the back end, the single shared 24x24 multiply-accumulate unit
// serves the three bins in turn for each sample (two partial products per bin); closing
// a window adds the three bin powers (sixteen partial products each) and two 32-step
// divisions. A two-entry queue in front keeps taking samples while the back end works,
// and the result waits in its own register.
module goertzel_bin_contrast (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [15:0] sample
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [62:0] target_power, [125:63] neighbor_power, [168:126] total_energy,
    // [200:169] score, [232:201] contrast, [245:233] window_length, [247:246] zero
    output logic [247:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    gbc_pkg::coeff_t  coeff_reg [gbc_pkg::NUM_BINS];
    gbc_pkg::item_t   q_item;
    gbc_pkg::result_t res;
    logic             q_valid, q_pop, cfg_wr;
    logic [1:0]       reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < gbc_pkg::NUM_BINS; i++) begin
                coeff_reg[i] <= '0;
            end
        end else if (cfg_wr) begin
            unique case (reg_idx)
                gbc_pkg::REG_COEFF_TARGET: coeff_reg[0] <= pwdata[gbc_pkg::COEFF_W-1:0];
                gbc_pkg::REG_COEFF_LOWER:  coeff_reg[1] <= pwdata[gbc_pkg::COEFF_W-1:0];
                gbc_pkg::REG_COEFF_UPPER:  coeff_reg[2] <= pwdata[gbc_pkg::COEFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            gbc_pkg::REG_COEFF_TARGET: prdata = 32'(coeff_reg[0]);
            gbc_pkg::REG_COEFF_LOWER:  prdata = 32'(coeff_reg[1]);
            gbc_pkg::REG_COEFF_UPPER:  prdata = 32'(coeff_reg[2]);
            default:                   prdata = '0;
        endcase
    end

    gbc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_sample (s_tdata),
        .s_last   (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    gbc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .coeff    (coeff_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (res)
    );

    assign m_tdata = {2'b00, res};

    // a result always covers at least one and at most a full window of samples
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[245:233] != 13'd0) &&
                     (m_tdata[245:233] <= gbc_pkg::MAX_WINDOW_SAMPLES))
        else $error("window length out of range");

    // no target power means both ratios are zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[62:0] == 63'd0) |->
            (m_tdata[200:169] == 32'd0) && (m_tdata[232:201] == 32'd0))
        else $error("nonzero ratio with zero target power");

endmodule

@@ sim/gbc_checker.sv @@
// checker for goertzel_bin_contrast: tracks coefficient writes, predicts each window result, compares
module gbc_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [15:0]  s_tdata,   // [15:0] sample
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [247:0] m_tdata,   // result_t in [245:0], [247:246] zero
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           errors,
    output int           pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;

    localparam wide_t ST_MAX  = 128'sh7FFF_FFFF_FFFF;
    localparam wide_t ST_MIN  = -128'sh8000_0000_0000;
    localparam wide_t PWR_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam wide_t Q_MAX   = 128'shFFFF_FFFF;

    gbc_pkg::coeff_t                      coef [gbc_pkg::NUM_BINS];
    logic signed [gbc_pkg::ST_W-1:0]      res_prev  [gbc_pkg::NUM_BINS];
    logic signed [gbc_pkg::ST_W-1:0]      res_prev2 [gbc_pkg::NUM_BINS];
    logic [63:0]                          energy_acc;
    int                                   win_count;
    gbc_pkg::result_t                     window_results [$];

    assign pending = window_results.size();

    // c * v in Q2.16, rounded half up
    function automatic wide_t round_q16(gbc_pkg::coeff_t c, logic signed [gbc_pkg::ST_W-1:0] v);
        wide_t p;
        p = c * v;
        return (p + 128'sd32768) >>> 16;
    endfunction

    function automatic logic [gbc_pkg::POW_W-1:0] bin_power(int k);
        wide_t p1, p2, acc;
        p1 = res_prev[k];
        p2 = res_prev2[k];
        acc = p2 * p2 + p1 * p1 - round_q16(coef[k], res_prev[k]) * p2;
        if (acc < 0) return '0;
        if (acc > PWR_MAX) return gbc_pkg::POW_MAX;
        return acc[gbc_pkg::POW_W-1:0];
    endfunction

    function automatic logic [gbc_pkg::Q_W-1:0] sat_ratio(wide_t num, wide_t den);
        wide_t q;
        q = num / den;
        return (q > Q_MAX) ? '1 : q[gbc_pkg::Q_W-1:0];
    endfunction

    function automatic void clear_window();
        for (int k = 0; k < gbc_pkg::NUM_BINS; k++) begin
            res_prev[k]  = '0;
            res_prev2[k] = '0;
        end
        energy_acc = '0;
        win_count  = 0;
    endfunction

    task automatic accept_sample(logic signed [15:0] x, logic close);
        wide_t   s;
        gbc_pkg::result_t r;
        logic [63:0] p1, p2, nb;
        for (int k = 0; k < gbc_pkg::NUM_BINS; k++) begin
            s = x;
            s = s + round_q16(coef[k], res_prev[k]) - res_prev2[k];
            if (s > ST_MAX) s = ST_MAX;
            if (s < ST_MIN) s = ST_MIN;
            res_prev2[k] = res_prev[k];
            res_prev[k]  = s[gbc_pkg::ST_W-1:0];
        end
        energy_acc = energy_acc + 64'(x * x);
        if (energy_acc > 64'(gbc_pkg::ENERGY_MAX)) energy_acc = 64'(gbc_pkg::ENERGY_MAX);
        win_count++;
        if (!close && win_count < 4096) return;
        r.target_power = bin_power(0);
        p1 = bin_power(1);
        p2 = bin_power(2);
        nb = (p1 + p2) >> 1;
        r.neighbor_power = nb[gbc_pkg::POW_W-1:0];
        r.total_energy   = energy_acc[gbc_pkg::EN_W-1:0];
        r.score    = sat_ratio(wide_t'(r.target_power) * 256000, wide_t'(energy_acc) + 1);
        r.contrast = sat_ratio(wide_t'(r.target_power) * 256, wide_t'(nb) + 1);
        r.window_length = gbc_pkg::LEN_W'(win_count);
        window_results.push_back(r);
        clear_window();
    endtask

    task automatic report(string field, logic [63:0] exp_v, logic [63:0] got_v);
        errors++;
        if (errors <= 10)
            $display("mismatch %s: expected %0d, got %0d at %0t", field, exp_v, got_v, $realtime);
    endtask

    always @(posedge aclk) begin
        gbc_pkg::result_t exp_r, got_r;
        if (!aresetn) begin
            for (int k = 0; k < gbc_pkg::NUM_BINS; k++) coef[k] = '0;
            clear_window();
            window_results.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[3:2] < 2'(gbc_pkg::NUM_BINS))
                coef[paddr[3:2]] = pwdata[gbc_pkg::COEFF_W-1:0];
            if (s_tvalid && s_tready) accept_sample(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got_r = m_tdata[$bits(gbc_pkg::result_t)-1:0];
                if (window_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result at %0t", $realtime);
                end else begin
                    exp_r = window_results.pop_front();
                    if (got_r.target_power != exp_r.target_power)
                        report("target_power", exp_r.target_power, got_r.target_power);
                    if (got_r.neighbor_power != exp_r.neighbor_power)
                        report("neighbor_power", exp_r.neighbor_power, got_r.neighbor_power);
                    if (got_r.total_energy != exp_r.total_energy)
                        report("total_energy", exp_r.total_energy, got_r.total_energy);
                    if (got_r.score != exp_r.score)
                        report("score", exp_r.score, got_r.score);
                    if (got_r.contrast != exp_r.contrast)
                        report("contrast", exp_r.contrast, got_r.contrast);
                    if (got_r.window_length != exp_r.window_length)
                        report("window_length", exp_r.window_length, got_r.window_length);
                    if (m_tdata[247:246] != 2'b00) report("pad bits", 0, m_tdata[247:246]);
                end
            end
        end
    end

endmodule

@@ sim/tb_goertzel_bin_contrast.sv @@
// testbench top for goertzel_bin_contrast: clock, reset, sample and register stimulus, verdict
module tb_goertzel_bin_contrast;
    timeunit 1ns;
    timeprecision 1ps;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid, s_tready, s_tlast;
    logic [15:0]  s_tdata;   // [15:0] sample
    logic         m_tvalid, m_tready;
    logic [247:0] m_tdata;   // see block port list
    logic         psel, penable, pwrite, pready;
    logic [3:0]   paddr;
    logic [31:0]  pwdata, prdata;
    int           errors, pending;

    bit quiet;
    int samples_sent, windows_sent, settings_used, results_taken;

    goertzel_bin_contrast uut (.*);

    gbc_checker chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #8ms;
        $display("timeout");
        $display("tb_goertzel_bin_contrast: done, errors");
        $finish;
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    task automatic send(logic [15:0] x, logic close);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= x;
        s_tlast  <= close;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        samples_sent++;
        if (close) windows_sent++;
    endtask

    // quiet point for register writes: no result owed and the back end drained
    task automatic settle();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    function automatic logic [15:0] draw_sample(int mode);
        case (mode)
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($signed($urandom_range(0, 64)) - 32);
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom_range(0, 65535)) >>> $urandom_range(0, 12);
        endcase
    endfunction

    function automatic logic [18:0] draw_coeff();
        return 19'($signed($urandom_range(0, 262144)) - 131072);
    endfunction

    // result side: random stalls, one long hold once a few results are out
    initial begin
        int gap;
        bit held;
        held = 0;
        m_tready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 8);
            if (!held && results_taken == 3) begin
                held = 1;
                m_tready <= 0;
                repeat (3000) @(posedge aclk);
            end else if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            results_taken++;
        end
    end

    initial begin
        int len, mode;
        aresetn = 0;
        s_tvalid = 0; s_tdata = 0; s_tlast = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        quiet = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: coefficient extremes, sample extremes, a longer window under output hold
        reg_write(gbc_pkg::REG_COEFF_TARGET, 32'h0001_ffff);
        reg_write(gbc_pkg::REG_COEFF_LOWER, 32'hfffe_0000);
        reg_write(gbc_pkg::REG_COEFF_UPPER, 32'h0);
        reg_write(2'd3, 32'hdead_beef);
        settings_used++;
        send(16'h7fff, 1);
        send(16'h8000, 1);
        send(16'h0000, 1);
        for (int i = 0; i < 8; i++) send(16'h7fff, i == 7);
        for (int i = 0; i < 8; i++) send(i[0] ? 16'h8000 : 16'h7fff, i == 7);
        for (int i = 0; i < 40; i++) send(16'h7fff, i == 39);
        send(16'h1234, 1);
        settle();
        reg_write(gbc_pkg::REG_COEFF_TARGET, 32'h0007_ffff);
        reg_write(gbc_pkg::REG_COEFF_LOWER, 32'h0002_0000);
        reg_write(gbc_pkg::REG_COEFF_UPPER, 32'h0001_ffff);
        settings_used++;
        for (int i = 0; i < 6; i++) send(16'h7fff, i == 5);
        send(16'h0001, 0);
        send(16'hffff, 1);
        settle();

        // random windows, coefficients redrawn per phase
        for (int ph = 0; samples_sent < 700; ph++) begin
            quiet = (ph % 3 == 2);
            reg_write(gbc_pkg::REG_COEFF_TARGET, {13'h0, draw_coeff()});
            reg_write(gbc_pkg::REG_COEFF_LOWER, {13'h0, draw_coeff()});
            reg_write(gbc_pkg::REG_COEFF_UPPER, {13'h0, draw_coeff()});
            settings_used++;
            for (int w = 0; w < 12; w++) begin
                len  = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
                mode = $urandom_range(0, 3);
                for (int i = 0; i < len; i++) send(draw_sample(mode), i == len - 1);
            end
            settle();
        end

        $display("%0d samples in %0d windows, %0d coefficient settings, %0d results checked",
                 samples_sent, windows_sent, settings_used, results_taken);
        if (errors == 0)
            $display("tb_goertzel_bin_contrast: done, clean");
        else
            $display("tb_goertzel_bin_contrast: done, errors");
        $finish;
    end

endmodule
